// ----- hdl/brl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants and types for the line rasterizer: error term headroom,
// command queue depth and the back end state encoding.
// ----------------------------------------------------------------------------
package brl_pkg;

  // extra bits over the coordinate width held by the error term and spans
  localparam int ERR_EXTRA = 3;

  // entries in the command queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // back end walker state
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAW
  } brl_state_t;

endpackage

// ----- hdl/brl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_front
// Command classifier: works out the spans, step directions and initial
// error term of a line item before it enters the command queue.
// ----------------------------------------------------------------------------
module brl_front #(
  parameter int COORD_BITS = 6,
  localparam int EW = COORD_BITS + brl_pkg::ERR_EXTRA
) (
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic signed [EW-1:0]         dx,
  output logic signed [EW-1:0]         dy,
  output logic signed [EW-1:0]         err0,
  output logic                         sx_pos,
  output logic                         sy_pos
);
  import brl_pkg::*;

  logic signed [EW-1:0] ddx;
  logic signed [EW-1:0] ddy;

  // signed differences, wide enough never to wrap
  assign ddx = EW'(x_end) - EW'(x_start);
  assign ddy = EW'(y_end) - EW'(y_start);

  // x span positive, y span kept negative as the error method wants
  assign dx   = ddx[EW-1] ? -ddx : ddx;
  assign dy   = ddy[EW-1] ? ddy : -ddy;
  assign err0 = dx + dy;

  // step directions: equal coordinates step negative but never move
  assign sx_pos = (x_start < x_end);
  assign sy_pos = (y_start < y_end);

endmodule

// ----- hdl/brl_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_fifo
// Small register queue with valid/ready on both sides, decoupling the
// command classifier from the pixel walker.
// ----------------------------------------------------------------------------
module brl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/brl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_back
// Pixel walker: holds the current pixel in the output register and steps
// the error term once for every pixel item taken by the sink but the last.
// ----------------------------------------------------------------------------
module brl_back #(
  parameter int COORD_BITS = 6,
  parameter int COLOR_BITS = 24,
  localparam int EW = COORD_BITS + brl_pkg::ERR_EXTRA
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command from the queue
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic signed [COORD_BITS-1:0] cmd_x,
  input  logic signed [COORD_BITS-1:0] cmd_y,
  input  logic signed [COORD_BITS-1:0] cmd_xe,
  input  logic signed [COORD_BITS-1:0] cmd_ye,
  input  logic signed [EW-1:0]         cmd_dx,
  input  logic signed [EW-1:0]         cmd_dy,
  input  logic signed [EW-1:0]         cmd_err,
  input  logic                         cmd_sx_pos,
  input  logic                         cmd_sy_pos,
  input  logic [COLOR_BITS-1:0]        cmd_color,
  // pixel items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0]        out_pixel_color,
  output logic                         out_last_pixel
);
  import brl_pkg::*;

  brl_state_t state_r, state_nxt;

  logic signed [COORD_BITS-1:0] x_r, y_r, xe_r, ye_r;
  logic signed [EW-1:0]         dx_r, dy_r, err_r;
  logic                         sx_pos_r, sy_pos_r;
  logic [COLOR_BITS-1:0]        color_r;
  logic [COORD_BITS-1:0]        cnt_r;

  logic signed [EW-1:0] e2;
  logic signed [EW-1:0] err_nxt;
  logic                 move_x, move_y;
  logic                 last;
  logic                 take_cmd;
  logic                 step;

  // last pixel: end point reached or pixel bound hit
  assign last = ((x_r == xe_r) && (y_r == ye_r)) || (cnt_r == '1);

  // error term step
  assign e2      = err_r <<< 1;
  assign move_x  = (e2 >= dy_r);
  assign move_y  = (e2 <= dx_r);
  assign err_nxt = err_r + (move_x ? dy_r : '0) + (move_y ? dx_r : '0);

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    cmd_ready = 1'b0;
    step      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
      end
      ST_DRAW: begin
        cmd_ready = out_ready && last;
        step      = out_ready && !last;
        if (out_ready && last && !cmd_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    take_cmd = cmd_valid && cmd_ready;
    if (take_cmd) begin
      state_nxt = ST_DRAW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // walker registers, the current pixel doubles as the output register
  always_ff @(posedge clk) begin
    if (take_cmd) begin
      x_r      <= cmd_x;
      y_r      <= cmd_y;
      xe_r     <= cmd_xe;
      ye_r     <= cmd_ye;
      dx_r     <= cmd_dx;
      dy_r     <= cmd_dy;
      err_r    <= cmd_err;
      sx_pos_r <= cmd_sx_pos;
      sy_pos_r <= cmd_sy_pos;
      color_r  <= cmd_color;
      cnt_r    <= '0;
    end else if (step) begin
      if (move_x) begin
        x_r <= sx_pos_r ? x_r + 1'b1 : x_r - 1'b1;
      end
      if (move_y) begin
        y_r <= sy_pos_r ? y_r + 1'b1 : y_r - 1'b1;
      end
      err_r <= err_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign out_valid       = (state_r == ST_DRAW);
  assign out_pixel_x     = x_r;
  assign out_pixel_y     = y_r;
  assign out_pixel_color = color_r;
  assign out_last_pixel  = last;

endmodule

// ----- hdl/bresenham_line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// All-octant integer line rasterizer: one line item in, one pixel item out
// for every point from the start point through the end point.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in_     | input     | in_valid / in_ready  | x/y start, x/y end, line_color
//   out_    | output    | out_valid / out_ready| pixel x/y, color, last_pixel
//
// A line of L pixels gives L pixel items, L = max(|dx|,|dy|) + 1, so 1 to
// 2^COORD_BITS items; the walker steps the error term between its pixel items.
// A line item taken into an empty block goes through a queue entry and then the
// walker registers; queued lines follow the previous last pixel with no gap.
// Reset empties the command queue and idles the walker.
// A stalled sink holds the current pixel; the two-entry queue keeps taking items until full.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 6,
  parameter int COLOR_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x_start,
  input  logic signed [COORD_BITS-1:0] in_y_start,
  input  logic signed [COORD_BITS-1:0] in_x_end,
  input  logic signed [COORD_BITS-1:0] in_y_end,
  input  logic [COLOR_BITS-1:0]        in_line_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOR_BITS-1:0]        out_pixel_color,
  output logic                         out_last_pixel
);
  import brl_pkg::*;

  localparam int EW = COORD_BITS + ERR_EXTRA;
  localparam int QW = 4 * COORD_BITS + 3 * EW + 2 + COLOR_BITS;

  logic signed [EW-1:0] f_dx, f_dy, f_err;
  logic                 f_sx_pos, f_sy_pos;
  logic [QW-1:0]        q_wr_data, q_rd_data;
  logic                 q_valid, q_ready;

  logic signed [COORD_BITS-1:0] q_x, q_y, q_xe, q_ye;
  logic signed [EW-1:0]         q_dx, q_dy, q_err;
  logic                         q_sx_pos, q_sy_pos;
  logic [COLOR_BITS-1:0]        q_color;

  // classify the line item
  brl_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .dx      (f_dx),
    .dy      (f_dy),
    .err0    (f_err),
    .sx_pos  (f_sx_pos),
    .sy_pos  (f_sy_pos)
  );

  assign q_wr_data = {in_x_start, in_y_start, in_x_end, in_y_end,
                      f_dx, f_dy, f_err, f_sx_pos, f_sy_pos, in_line_color};

  // command queue
  brl_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rd_data)
  );

  assign {q_x, q_y, q_xe, q_ye, q_dx, q_dy, q_err, q_sx_pos, q_sy_pos, q_color} =
    q_rd_data;

  // walk the line
  brl_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd_ready       (q_ready),
    .cmd_x           (q_x),
    .cmd_y           (q_y),
    .cmd_xe          (q_xe),
    .cmd_ye          (q_ye),
    .cmd_dx          (q_dx),
    .cmd_dy          (q_dy),
    .cmd_err         (q_err),
    .cmd_sx_pos      (q_sx_pos),
    .cmd_sy_pos      (q_sy_pos),
    .cmd_color       (q_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
